// ===== hdl/rme_pkg.sv =====
package rme_pkg;

	localparam int unsigned IN_W   = 16;
	localparam int unsigned CFG_W  = 15;
	localparam int unsigned CY_W   = 15;
	localparam int unsigned SQ_W   = 32;
	localparam int unsigned OP_W   = 17;
	localparam int unsigned XY_W   = 36;
	localparam int unsigned Z_W    = 24;
	localparam int unsigned ATAN_W = 20;
	localparam int unsigned RND_W  = Z_W - 7;
	localparam int unsigned SQ_STAGES = 16;

	localparam logic [CFG_W-1:0] GIMBAL_RESET = CFG_W'(16);
	localparam logic signed [IN_W-1:0] ONE_Q14 = IN_W'(16384);
	localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(32'h1000_0000);
	localparam logic signed [Z_W-1:0] HALF_PI_Z = Z_W'(1647099);
	localparam logic signed [RND_W-1:0] PI_OUT = RND_W'(25736);
	localparam logic signed [RND_W-1:0] HALF_PI_OUT = RND_W'(12868);

	localparam logic [ATAN_W-1:0] ATAN_TAB [32] = '{
		20'd823550, 20'd486170, 20'd256879, 20'd130396, 20'd65451, 20'd32757,
		20'd16383, 20'd8192, 20'd4096, 20'd2048, 20'd1024, 20'd512, 20'd256,
		20'd128, 20'd64, 20'd32, 20'd16, 20'd8, 20'd4, 20'd2, 20'd1,
		20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0
	};

	typedef struct packed {
		logic signed [IN_W-1:0] r00;
		logic signed [IN_W-1:0] r01;
		logic signed [IN_W-1:0] r10;
		logic signed [IN_W-1:0] r11;
		logic signed [IN_W-1:0] r21;
		logic signed [IN_W-1:0] r22;
		logic signed [IN_W-1:0] sy;
	} side_t;

endpackage

// ===== hdl/rme_in_if.sv =====
interface rme_in_if;
	import rme_pkg::*;
	logic valid;
	logic ready;
	logic signed [IN_W-1:0] r00;
	logic signed [IN_W-1:0] r01;
	logic signed [IN_W-1:0] r10;
	logic signed [IN_W-1:0] r11;
	logic signed [IN_W-1:0] r20;
	logic signed [IN_W-1:0] r21;
	logic signed [IN_W-1:0] r22;
	modport source(output valid, r00, r01, r10, r11, r20, r21, r22, input ready);
	modport sink(input valid, r00, r01, r10, r11, r20, r21, r22, output ready);
endinterface

// ===== hdl/rme_out_if.sv =====
interface rme_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] roll;
	logic signed [14:0] pitch;
	logic signed [15:0] yaw;
	modport source(output valid, roll, pitch, yaw, input ready);
	modport sink(input valid, roll, pitch, yaw, output ready);
endinterface

// ===== hdl/rotation_matrix_to_euler_xyz.sv =====
// Rotation matrix to XYZ Euler angles.
// Channel mat carries seven Q2.14 matrix elements in one beat; channel ang
// returns roll, pitch and yaw (8192 = 1 rad) in one beat per matrix.
// gimbal_limit_we / gimbal_limit_wd write the gimbal limit; write it only
// while no matrix is in flight.
// Pipeline: input stage, 16 square-root stages, CORDIC pre-rotation plus one
// stage per iteration, output stage. Throughput: one matrix per cycle while
// the receiver does not stall, set by the fully pipelined square root and the
// three CORDIC lanes.
// Reset clears every stage valid bit and loads the limit with 16.
// When the receiver stalls the whole pipeline holds; a new beat is still
// taken while the output register is empty or being drained this cycle.
// Lanes: pitch lane runs atan2(sy, cy); roll lane runs either
// atan2(r21, r22) or atan2(-r01, r11), chosen once cy is known; yaw lane
// runs atan2(r10, r00) and is dropped to zero on the gimbal lock path.
module rotation_matrix_to_euler_xyz
	import rme_pkg::*;
#(
	parameter int unsigned CORDIC_STEPS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             gimbal_limit_we,
	input  logic [CFG_W-1:0] gimbal_limit_wd,
	rme_in_if.sink           mat,
	rme_out_if.source        ang
);
	localparam int unsigned SIDE_LEN = SQ_STAGES + 1;
	localparam int unsigned LANE_LAT = CORDIC_STEPS + 1;
	localparam int unsigned LAT      = SIDE_LEN + LANE_LAT + 1;

	logic [CFG_W-1:0] gimbal_q;
	logic [LAT-1:0]   vld_q;
	logic             adv;

	// advance everything unless the output beat is held by the receiver
	assign adv       = !vld_q[LAT-1] || ang.ready;
	assign mat.ready = adv;
	assign ang.valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gimbal_q <= GIMBAL_RESET;
			vld_q    <= '0;
		end else begin
			if (gimbal_limit_we) gimbal_q <= gimbal_limit_wd;
			if (adv) vld_q <= {vld_q[LAT-2:0], mat.valid};
		end
	end

	// input stage: clamp the sine, form 1 - sy^2
	logic signed [IN_W:0]   neg_r20;
	logic signed [IN_W-1:0] sy;
	logic [SQ_W-1:0]        sq;
	logic [SQ_W-1:0]        v_s1;
	side_t                  side_q [SIDE_LEN];

	always_comb begin
		neg_r20 = -(IN_W+1)'(mat.r20);
		if (neg_r20 > (IN_W+1)'(ONE_Q14))       sy = ONE_Q14;
		else if (neg_r20 < -(IN_W+1)'(ONE_Q14)) sy = -ONE_Q14;
		else                                    sy = neg_r20[IN_W-1:0];
		// square at full width so that 1.0 squared keeps its top bit
		sq = SQ_W'($unsigned(SQ_W'(sy) * SQ_W'(sy)));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1          <= ONE_SQ - sq;
			side_q[0].r00 <= mat.r00;
			side_q[0].r01 <= mat.r01;
			side_q[0].r10 <= mat.r10;
			side_q[0].r11 <= mat.r11;
			side_q[0].r21 <= mat.r21;
			side_q[0].r22 <= mat.r22;
			side_q[0].sy  <= sy;
			for (int k = 1; k < SIDE_LEN; k++) side_q[k] <= side_q[k-1];
		end
	end

	logic [CY_W-1:0] cy;
	rme_isqrt u_isqrt (.clk(clk), .en(adv), .v_in(v_s1), .root(cy));

	// choose lane operands now that the cosine is known
	side_t                  sd;
	logic                   lock;
	logic signed [OP_W-1:0] roll_y, roll_x;
	logic                   lock_q [LANE_LAT];

	always_comb begin
		sd     = side_q[SIDE_LEN-1];
		lock   = !(cy > gimbal_q);
		roll_y = lock ? -OP_W'(sd.r01) : OP_W'(sd.r21);
		roll_x = lock ?  OP_W'(sd.r11) : OP_W'(sd.r22);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lock_q[0] <= lock;
			for (int k = 1; k < LANE_LAT; k++) lock_q[k] <= lock_q[k-1];
		end
	end

	logic signed [Z_W-1:0] z_pitch, z_roll, z_yaw;
	logic                  zr_pitch, zr_roll, zr_yaw;

	rme_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
		.clk(clk), .en(adv), .y_in(OP_W'(sd.sy)),
		.x_in(OP_W'($signed({2'b00, cy}))), .z_out(z_pitch), .zero_out(zr_pitch)
	);
	rme_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
		.clk(clk), .en(adv), .y_in(roll_y), .x_in(roll_x),
		.z_out(z_roll), .zero_out(zr_roll)
	);
	rme_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
		.clk(clk), .en(adv), .y_in(OP_W'(sd.r10)), .x_in(OP_W'(sd.r00)),
		.z_out(z_yaw), .zero_out(zr_yaw)
	);

	// merge: round to the output scale, zero the angle of a zero vector, clamp, drop yaw on gimbal lock
	function automatic logic signed [RND_W-1:0] round_clamp(
		input logic signed [Z_W-1:0]   z,
		input logic                    zero,
		input logic signed [RND_W-1:0] lim
	);
		logic signed [Z_W-1:0]   zr;
		logic signed [RND_W-1:0] r;
		zr = (z + Z_W'(64)) >>> 7;
		r  = zero ? '0 : zr[RND_W-1:0];
		if (r > lim)       return lim;
		else if (r < -lim) return -lim;
		else               return r;
	endfunction

	logic signed [RND_W-1:0] roll_r, pitch_r, yaw_r;
	assign roll_r  = round_clamp(z_roll, zr_roll, PI_OUT);
	assign pitch_r = round_clamp(z_pitch, zr_pitch, HALF_PI_OUT);
	assign yaw_r   = round_clamp(z_yaw, zr_yaw || lock_q[LANE_LAT-1], PI_OUT);

	logic signed [15:0] roll_q, yaw_q;
	logic signed [14:0] pitch_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			roll_q  <= roll_r[15:0];
			pitch_q <= pitch_r[14:0];
			yaw_q   <= yaw_r[15:0];
		end
	end

	assign ang.roll  = roll_q;
	assign ang.pitch = pitch_q;
	assign ang.yaw   = yaw_q;
endmodule

// ===== hdl/rme_isqrt.sv =====
module rme_isqrt
	import rme_pkg::*;
(
	input  logic            clk,
	input  logic            en,
	input  logic [SQ_W-1:0] v_in,
	output logic [CY_W-1:0] root
);
	logic [SQ_W-1:0] v_s   [SQ_STAGES+1];
	logic [SQ_W-1:0] res_s [SQ_STAGES+1];

	assign v_s[0]   = v_in;
	assign res_s[0] = '0;

	// one result bit per stage, highest first
	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (30 - 2 * k);
		logic [SQ_W-1:0] trial;
		assign trial = res_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (v_s[k] >= trial) begin
					v_s[k+1]   <= v_s[k] - trial;
					res_s[k+1] <= (res_s[k] >> 1) + BIT;
				end else begin
					v_s[k+1]   <= v_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
			end
		end
	end

	assign root = res_s[SQ_STAGES][CY_W-1:0];
endmodule

// ===== hdl/rme_cordic.sv =====
module rme_cordic
	import rme_pkg::*;
#(
	parameter int unsigned STEPS = 16
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [OP_W-1:0] y_in,
	input  logic signed [OP_W-1:0] x_in,
	output logic signed [Z_W-1:0]  z_out,
	output logic                   zero_out
);
	logic signed [XY_W-1:0] x_s [STEPS+1];
	logic signed [XY_W-1:0] y_s [STEPS+1];
	logic signed [Z_W-1:0]  z_s [STEPS+1];
	logic                   zero_s [STEPS+1];

	logic signed [XY_W-1:0] xw, yw;
	assign xw = XY_W'(x_in) <<< 16;
	assign yw = XY_W'(y_in) <<< 16;

	// turn a left half-plane vector by a quarter turn
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				if (y_in >= 0) begin
					x_s[0] <= yw;
					y_s[0] <= -xw;
					z_s[0] <= HALF_PI_Z;
				end else begin
					x_s[0] <= -yw;
					y_s[0] <= xw;
					z_s[0] <= -HALF_PI_Z;
				end
			end else begin
				x_s[0] <= xw;
				y_s[0] <= yw;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic signed [Z_W-1:0] ANG = Z_W'(ATAN_TAB[i % 32]);
		logic signed [XY_W-1:0] dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + ANG;
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - ANG;
				end
			end
		end
	end

	assign z_out    = z_s[STEPS];
	assign zero_out = zero_s[STEPS];
endmodule

// ===== test/euler_checker.sv =====
`timescale 1ns / 100ps
module euler_checker
	import rme_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             limit_we,
	input  logic [CFG_W-1:0] limit_wd,
	input  logic             mat_valid,
	input  logic             mat_ready,
	input  logic signed [15:0] r00, r01, r10, r11, r20, r21, r22,
	input  logic             ang_valid,
	input  logic             ang_ready,
	input  logic signed [15:0] roll,
	input  logic signed [14:0] pitch,
	input  logic signed [15:0] yaw,
	output int               errors,
	output int               pending,
	output int               beats_out
);
	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
	} angles_t;

	angles_t expected_angles[$];
	logic [CFG_W-1:0] limit_copy;

	function automatic longint floor_shift(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -(((-v) - 1) >>> s) - 1;
	endfunction

	function automatic longint bound(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic int unsigned root_floor(int unsigned v);
		int unsigned res;
		int unsigned b;
		res = 0;
		b = 32'h4000_0000;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// vectoring-mode atan2, 2^20 per radian inside, 8192 per radian out
	function automatic longint vector_angle(longint y, longint x);
		longint z, t, dx, dy;
		if (x == 0 && y == 0)
			return 0;
		x = x * 65536;
		y = y * 65536;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = 1647099;
			end else begin
				t = x; x = -y; y = t; z = -1647099;
			end
		end
		for (int i = 0; i < 16; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (y > 0) begin
				x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
			end else begin
				x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
			end
		end
		return floor_shift(z + 64, 7);
	endfunction

	function automatic angles_t decompose(longint m00, longint m01, longint m10,
			longint m11, longint m20, longint m21, longint m22);
		angles_t a;
		longint sine, cosine, rl, yw;
		sine = bound(-m20, 16384);
		cosine = root_floor(32'(268435456 - sine * sine));
		a.pitch = 15'(bound(vector_angle(sine, cosine), 12868));
		if (cosine > longint'(limit_copy)) begin
			rl = vector_angle(m21, m22);
			yw = vector_angle(m10, m00);
		end else begin
			rl = vector_angle(-m01, m11);
			yw = 0;
		end
		a.roll = 16'(bound(rl, 25736));
		a.yaw = 16'(bound(yw, 25736));
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		angles_t got, want;
		if (!arst_n) begin
			limit_copy <= GIMBAL_RESET;
			errors = 0;
			beats_out = 0;
			expected_angles.delete();
		end else begin
			if (mat_valid && mat_ready)
				expected_angles.insert(expected_angles.size(),
					decompose(r00, r01, r10, r11, r20, r21, r22));
			if (ang_valid && ang_ready) begin
				got = '{roll, pitch, yaw};
				beats_out++;
				if (expected_angles.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat roll %0d pitch %0d yaw %0d",
						$time, roll, pitch, yaw);
				end else begin
					want = expected_angles.pop_front();
					if (got.roll !== want.roll) begin
						errors++;
						$display("%0t: roll expected %0d actual %0d", $time, want.roll, got.roll);
					end
					if (got.pitch !== want.pitch) begin
						errors++;
						$display("%0t: pitch expected %0d actual %0d",
							$time, want.pitch, got.pitch);
					end
					if (got.yaw !== want.yaw) begin
						errors++;
						$display("%0t: yaw expected %0d actual %0d", $time, want.yaw, got.yaw);
					end
				end
			end
			if (limit_we)
				limit_copy <= limit_wd;
		end
		pending = expected_angles.size();
	end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
	import rme_pkg::*;

	localparam int WATCHDOG = 2000;
	localparam int DRAIN = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic limit_we = 1'b0;
	logic [CFG_W-1:0] limit_wd = '0;
	int errors, pending, beats_out;
	int idle_src, idle_snk;
	int beats_in = 0;
	int quiet = 0;

	rme_in_if mat();
	rme_out_if ang();

	rotation_matrix_to_euler_xyz u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.gimbal_limit_we (limit_we),
		.gimbal_limit_wd (limit_wd),
		.mat             (mat.sink),
		.ang             (ang.source)
	);

	euler_checker u_check (
		.clk(clk), .arst_n(arst_n), .limit_we(limit_we), .limit_wd(limit_wd),
		.mat_valid(mat.valid), .mat_ready(mat.ready),
		.r00(mat.r00), .r01(mat.r01), .r10(mat.r10), .r11(mat.r11),
		.r20(mat.r20), .r21(mat.r21), .r22(mat.r22),
		.ang_valid(ang.valid), .ang_ready(ang.ready),
		.roll(ang.roll), .pitch(ang.pitch), .yaw(ang.yaw),
		.errors(errors), .pending(pending), .beats_out(beats_out)
	);

	always #5 clk = ~clk;

	// receiver: stall at the current rate, sampled per falling edge
	initial ang.ready = 1'b0;
	always @(negedge clk)
		ang.ready <= ($urandom_range(99) >= idle_snk);

	// watchdog: count cycles with no beat on either side, stop the run at the limit
	always @(posedge clk) begin
		if ((mat.valid && mat.ready) || (ang.valid && ang.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (mat.valid && mat.ready)
			beats_in <= beats_in + 1;
		if (quiet >= WATCHDOG) begin
			$display("Stopped after %0d matrices in, %0d angle beats out,", beats_in, beats_out);
			$display("%0d cycles without a beat.", quiet);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// present one beat and hold until accepted; gaps at the sender rate,
	// valid stays up so that the next beat can follow at once
	task automatic send_matrix(input logic [15:0] a00, a01, a10, a11, a20, a21, a22);
		while ($urandom_range(99) < idle_src) begin
			mat.valid <= 1'b0;
			@(negedge clk);
		end
		mat.valid <= 1'b1;
		{mat.r00, mat.r01, mat.r10, mat.r11} <= {a00, a01, a10, a11};
		{mat.r20, mat.r21, mat.r22} <= {a20, a21, a22};
		@(posedge clk);
		while (!mat.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// drop valid, hold until every angle beat is back, then let the pipe empty
	task automatic drain_pipe();
		mat.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_limit(input logic [CFG_W-1:0] v);
		drain_pipe();
		limit_we <= 1'b1;
		limit_wd <= v;
		@(negedge clk);
		limit_we <= 1'b0;
	endtask

	function automatic logic [15:0] near_unit();
		// mostly plausible rotation entries, sometimes anything
		if ($urandom_range(3) == 0)
			return 16'($urandom);
		return 16'($signed($urandom_range(32768)) - 16384);
	endfunction

	// a pitch near +-90 deg so the gimbal limit matters
	function automatic logic [15:0] steep_r20();
		int off;
		off = $urandom_range(300);
		return $urandom_range(1) ? 16'(16384 - off) : 16'(-16384 + off);
	endfunction

	task automatic random_run(input int n, input int pct_steep);
		logic [15:0] s;
		for (int i = 0; i < n; i++) begin
			s = ($urandom_range(99) < pct_steep) ? steep_r20() : near_unit();
			send_matrix(near_unit(), near_unit(), near_unit(), near_unit(), s,
				near_unit(), near_unit());
		end
	endtask

	initial begin
		logic [CFG_W-1:0] limits [6];
		limits = '{15'd0, 15'd16, 15'd200, 15'd16384, 15'd32767, 15'd1000};
		mat.valid = 1'b0;
		{mat.r00, mat.r01, mat.r10, mat.r11, mat.r20, mat.r21, mat.r22} = '0;
		idle_src = 0;
		idle_snk = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: identity, zero vectors, extremes, clamped sine, every quadrant
		send_matrix(16384, 0, 0, 16384, 0, 0, 16384);
		send_matrix(0, 0, 0, 0, 0, 0, 0);
		send_matrix(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_matrix(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_matrix(-16384, 0, 0, -16384, 0, 0, -16384);
		send_matrix(-100, 5, -7, 100, 0, -9, -200);
		send_matrix(-300, -5, 9, -1, 0, 3, -1);
		send_matrix(0, 16384, 16384, 0, 16384, 16384, 0);
		send_matrix(0, -16384, -16384, 0, -16384, -16384, 0);
		send_matrix(0, 0, 0, 0, 16'h8000, 0, 0);
		send_matrix(0, 16'h7fff, 0, 16'h8000, 20000, 0, 0);
		send_matrix(5, 0, 1, 0, 16383, 0, 0);
		send_matrix(-1, 1, 1, -1, -16383, 1, -1);
		send_matrix(1, 0, 0, 1, 0, 16'h8000, 16'h8000);

		// pause: let every expected beat come home before going on
		drain_pipe();

		// sweep settings through the idling phases
		foreach (limits[k]) begin
			write_limit(limits[k]);
			case (k % 4)
				0: begin idle_src = 0;  idle_snk = 0;  end
				1: begin idle_src = 66; idle_snk = 0;  end
				2: begin idle_src = 0;  idle_snk = 66; end
				default: begin idle_src = 26; idle_snk = 26; end
			endcase
			random_run(165, 30);
		end
		idle_src = 0;
		idle_snk = 0;

		drain_pipe();
		$display("Covered %0d matrices in, %0d angle beats out, six gimbal limits,",
			beats_in, beats_out);
		$display("four idling phases and a full pipe drain.");
		if (errors == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ===== files.f =====
hdl/rme_pkg.sv
hdl/rme_in_if.sv
hdl/rme_out_if.sv
hdl/rme_isqrt.sv
hdl/rme_cordic.sv
hdl/rotation_matrix_to_euler_xyz.sv
test/euler_checker.sv
test/testbench.sv
